FILE: design/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared sizes, codes, record layouts and helpers of the bucket priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

  localparam int NUM_ELEMENTS = 4096;
  localparam int NUM_BUCKETS  = 256;

  localparam int ELEM_W   = $clog2(NUM_ELEMENTS);
  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int LINK_W   = ELEM_W + 1;    // index plus nil flag on top
  localparam int SP_W     = BUCKET_W + 1;  // scan pointer reaches NUM_BUCKETS
  localparam int CNT_W    = ELEM_W + 1;    // gray count reaches NUM_ELEMENTS
  localparam int ACTION_W = 3;
  localparam int CFG_W    = 9;
  localparam int COLOR_W  = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(256);

  typedef logic [ELEM_W-1:0]   elem_t;
  typedef logic [LINK_W-1:0]   link_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [ACTION_W-1:0] action_t;

  // action codes; unused codes behave as a query
  localparam action_t ACT_INSERT   = 3'd0;
  localparam action_t ACT_REMOVE   = 3'd1;
  localparam action_t ACT_MOVE     = 3'd2;
  localparam action_t ACT_WITHDRAW = 3'd3;
  localparam action_t ACT_QUERY    = 3'd4;

  localparam color_t COLOR_WHITE = 2'd0;
  localparam color_t COLOR_GRAY  = 2'd1;
  localparam color_t COLOR_BLACK = 2'd2;

  localparam link_t LINK_NIL = {1'b1, {ELEM_W{1'b0}}};

  typedef struct packed {
    action_t action;
    elem_t   elem;
    bucket_t bucket;
    bucket_t to_bucket;
  } cmd_t;

  typedef struct packed {
    elem_t  result_elem;
    logic   none_found;
    color_t elem_color;
    logic   queue_empty;
  } result_t;

  // one element memory word
  typedef struct packed {
    link_t  nxt;
    link_t  prv;
    color_t col;
  } elem_rec_t;

  // one bucket memory word; head emptiness lives in a flop vector
  typedef struct packed {
    elem_t head;
    link_t tail;
  } bkt_rec_t;

  localparam int ELEM_REC_W = $bits(elem_rec_t);
  localparam int BKT_REC_W  = $bits(bkt_rec_t);

  function automatic logic link_ok(input link_t l);
    return !l[ELEM_W];
  endfunction

endpackage

`default_nettype wire

FILE: design/bucket_priority_queue.sv
// ----------------------------------------------------------------------------
// bucket_priority_queue
// Monotone bucket priority queue with doubly linked FIFO buckets and colors.
// ----------------------------------------------------------------------------
// Operation: one item at a time; the next is taken in the cycle after the result
//   is registered.
// Reset: rst sweeps the element memory to white with item_stall high;
//   configuration writes are taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module bucket_priority_queue (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [bpq_pkg::CFG_W-1:0]       cfg_wdata,
  // item channel
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic [bpq_pkg::ACTION_W-1:0]    action,
  input  wire logic [bpq_pkg::ELEM_W-1:0]      elem,
  input  wire logic [bpq_pkg::BUCKET_W-1:0]    bucket,
  input  wire logic [bpq_pkg::BUCKET_W-1:0]    to_bucket,
  // result channel
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [bpq_pkg::ELEM_W-1:0]           result_elem,
  output logic                                 none_found,
  output logic [bpq_pkg::COLOR_W-1:0]          elem_color,
  output logic                                 queue_empty
);

  // Number of buckets the minimum scan may visit; saturated to the bucket
  // count so the scan pointer never indexes past the bucket memory.
  logic [bpq_pkg::CFG_W-1:0] active_buckets;
  logic [bpq_pkg::SP_W-1:0]  lim;

  logic             eng_idle;
  logic             eng_res_valid;
  bpq_pkg::result_t eng_res;
  bpq_pkg::cmd_t    cmd;
  logic             accept;
  logic             take;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_buckets <= bpq_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_buckets <= cfg_wdata;
    end
  end

  assign lim = (active_buckets > bpq_pkg::CFG_W'(bpq_pkg::NUM_BUCKETS)) ?
               bpq_pkg::SP_W'(bpq_pkg::NUM_BUCKETS) :
               bpq_pkg::SP_W'(active_buckets);

  // The engine takes a beat only when it sits idle; it runs one operation
  // to completion, then parks its result until the output register frees up.
  assign item_stall = !eng_idle;
  assign accept     = item_valid && !item_stall;
  assign cmd        = '{action: action, elem: elem, bucket: bucket, to_bucket: to_bucket};

  // Output register: holds a finished beat while the engine goes on with the
  // next item. Free when empty or when the current beat leaves this cycle.
  assign take     = result_valid && !result_stall;
  assign out_free = !result_valid || take;

  bpq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .cmd       (cmd),
    .lim       (lim),
    .out_free  (out_free),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (eng_res_valid && out_free) begin
      result_valid <= 1'b1;
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && out_free) begin
      result_elem <= eng_res.result_elem;
      none_found  <= eng_res.none_found;
      elem_color  <= eng_res.elem_color;
      queue_empty <= eng_res.queue_empty;
    end
  end

`ifndef SYNTHESIS
  // an accepted beat always puts the engine to work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("engine still idle after accepting a beat");

  // the memory sweep keeps the item side closed right after reset
  a_reset_stall: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("item accepted during the clearing sweep");

  // an empty scan reports element zero and white
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && none_found |->
      (result_elem == '0) && (elem_color == bpq_pkg::COLOR_WHITE))
    else $error("empty remove_min result carries element data");
`endif

endmodule

`default_nettype wire

FILE: design/bpq_ram.sv
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/bpq_engine.sv
// ----------------------------------------------------------------------------
// bpq_engine
// Sequencer over the element and bucket memories: one operation at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpq_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire bpq_pkg::cmd_t                cmd,
  input  wire logic [bpq_pkg::SP_W-1:0]     lim,
  input  wire logic                         out_free,
  output logic                              idle,
  output logic                              res_valid,
  output bpq_pkg::result_t                  res
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_CHECK,
    ST_SCAN, ST_M_HEAD, ST_M_ELEM, ST_M_COL,
    ST_A_FETCH, ST_A_CHECK, ST_A_SELF, ST_A_DONE,
    ST_D_NEXT, ST_D_COL, ST_D_DONE,
    ST_U_RD, ST_U_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {FLD_NXT, FLD_PRV, FLD_COL} fld_t;

  state_t                          state;
  logic [bpq_pkg::ELEM_W-1:0]      clr_idx;
  bpq_pkg::action_t                act;
  bpq_pkg::elem_t                  e_r;
  bpq_pkg::bucket_t                b_r;
  bpq_pkg::bucket_t                to_r;
  bpq_pkg::bucket_t                tgt;
  logic [bpq_pkg::NUM_BUCKETS-1:0] occ;
  logic [bpq_pkg::SP_W-1:0]        sp;
  logic [bpq_pkg::CNT_W-1:0]       count;
  bpq_pkg::link_t                  p_r;
  bpq_pkg::link_t                  n_r;
  bpq_pkg::link_t                  t_r;
  bpq_pkg::elem_t                  bh_r;
  bpq_pkg::link_t                  bt_r;
  bpq_pkg::color_t                 color_r;
  logic                            none_r;
  bpq_pkg::elem_t                  u_addr;
  fld_t                            u_field;
  bpq_pkg::link_t                  u_val;
  state_t                          u_ret;

  // memory ports
  logic                               e_we;
  bpq_pkg::elem_t                     e_waddr;
  bpq_pkg::elem_rec_t                 e_wdata;
  bpq_pkg::elem_t                     e_raddr;
  logic [bpq_pkg::ELEM_REC_W-1:0]     e_rdata;
  logic                               b_we;
  bpq_pkg::bucket_t                   b_waddr;
  bpq_pkg::bkt_rec_t                  b_wdata;
  bpq_pkg::bucket_t                   b_raddr;
  logic [bpq_pkg::BKT_REC_W-1:0]      b_rdata;

  bpq_pkg::elem_rec_t er;
  bpq_pkg::bkt_rec_t  br;
  bpq_pkg::elem_rec_t upd_rec;
  bpq_pkg::bucket_t   sp_idx;
  logic               n_ok;
  logic               p_ok;
  logic               is_head;
  logic               do_detach;

  assign er        = e_rdata;
  assign br        = b_rdata;
  assign sp_idx    = sp[bpq_pkg::BUCKET_W-1:0];
  assign n_ok      = bpq_pkg::link_ok(er.nxt);
  assign p_ok      = bpq_pkg::link_ok(er.prv);
  assign is_head   = occ[b_r] && (br.head == e_r);
  assign do_detach = ((act == bpq_pkg::ACT_MOVE) || (act == bpq_pkg::ACT_WITHDRAW)) &&
                     (er.col == bpq_pkg::COLOR_GRAY);

  bpq_ram #(.WIDTH(bpq_pkg::ELEM_REC_W), .DEPTH(bpq_pkg::NUM_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bpq_ram #(.WIDTH(bpq_pkg::BKT_REC_W), .DEPTH(bpq_pkg::NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // single-field read-modify-write of an element word
  always_comb begin
    upd_rec = er;
    case (u_field)
      FLD_NXT: upd_rec.nxt = u_val;
      FLD_PRV: upd_rec.prv = u_val;
      FLD_COL: upd_rec.col = u_val[bpq_pkg::COLOR_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    e_we    = 1'b0;
    e_waddr = e_r;
    e_wdata = upd_rec;
    e_raddr = e_r;
    b_we    = 1'b0;
    b_waddr = b_r;
    b_wdata = br;
    b_raddr = b_r;
    case (state)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_idx;
        e_wdata = '{nxt: '0, prv: '0, col: bpq_pkg::COLOR_WHITE};
      end
      ST_CHECK: begin
        // head of its bucket: unlink in the bucket word right away
        if (do_detach && is_head) begin
          b_we = 1'b1;
          if (n_ok) begin
            b_wdata = '{head: er.nxt[bpq_pkg::ELEM_W-1:0], tail: br.tail};
          end else begin
            b_wdata = '{head: br.head, tail: bpq_pkg::LINK_NIL};
          end
        end
      end
      ST_SCAN: begin
        b_raddr = sp_idx;
      end
      ST_M_HEAD: begin
        e_raddr = br.head;
      end
      ST_M_ELEM: begin
        b_we    = 1'b1;
        b_waddr = sp_idx;
        if (n_ok) begin
          b_wdata = '{head: er.nxt[bpq_pkg::ELEM_W-1:0], tail: bt_r};
        end else begin
          b_wdata = '{head: bh_r, tail: bpq_pkg::LINK_NIL};
          e_we    = 1'b1;
          e_wdata = '{nxt: er.nxt, prv: er.prv, col: bpq_pkg::COLOR_BLACK};
        end
      end
      ST_A_FETCH: begin
        b_raddr = tgt;
      end
      ST_A_CHECK: begin
        b_we    = 1'b1;
        b_waddr = tgt;
        if (!occ[tgt]) begin
          b_wdata = '{head: e_r, tail: {1'b0, e_r}};
          e_we    = 1'b1;
          e_wdata = '{nxt: bpq_pkg::LINK_NIL, prv: bpq_pkg::LINK_NIL,
                      col: bpq_pkg::COLOR_GRAY};
        end else begin
          b_wdata = '{head: br.head, tail: {1'b0, e_r}};
        end
      end
      ST_A_SELF: begin
        e_we    = 1'b1;
        e_wdata = '{nxt: bpq_pkg::LINK_NIL, prv: t_r, col: bpq_pkg::COLOR_GRAY};
      end
      ST_D_NEXT: begin
        if (!bpq_pkg::link_ok(n_r)) begin
          b_we    = 1'b1;
          b_wdata = '{head: bh_r, tail: p_r};
        end
      end
      ST_U_RD: begin
        e_raddr = u_addr;
      end
      ST_U_WR: begin
        e_we    = 1'b1;
        e_waddr = u_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      occ     <= '0;
      sp      <= '0;
      count   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == {bpq_pkg::ELEM_W{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            act     <= cmd.action;
            e_r     <= cmd.elem;
            b_r     <= cmd.bucket;
            to_r    <= cmd.to_bucket;
            tgt     <= cmd.bucket;
            none_r  <= 1'b0;
            color_r <= bpq_pkg::COLOR_WHITE;
            state   <= (cmd.action == bpq_pkg::ACT_REMOVE) ? ST_SCAN : ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          color_r <= er.col;
          p_r     <= er.prv;
          n_r     <= er.nxt;
          bh_r    <= br.head;
          if (act == bpq_pkg::ACT_INSERT) begin
            state <= (er.col == bpq_pkg::COLOR_GRAY) ? ST_DONE : ST_A_FETCH;
          end else if (do_detach) begin
            if (is_head) begin
              occ[b_r] <= n_ok;
              if (n_ok) begin
                u_addr  <= er.nxt[bpq_pkg::ELEM_W-1:0];
                u_field <= FLD_PRV;
                u_val   <= bpq_pkg::LINK_NIL;
                u_ret   <= ST_D_COL;
                state   <= ST_U_RD;
              end else begin
                state <= ST_D_COL;
              end
            end else if (p_ok) begin
              u_addr  <= er.prv[bpq_pkg::ELEM_W-1:0];
              u_field <= FLD_NXT;
              u_val   <= er.nxt;
              u_ret   <= ST_D_NEXT;
              state   <= ST_U_RD;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (sp >= lim) begin
            none_r  <= 1'b1;
            e_r     <= '0;
            color_r <= bpq_pkg::COLOR_WHITE;
            state   <= ST_DONE;
          end else if (!occ[sp_idx]) begin
            sp <= sp + 1'b1;
          end else begin
            state <= ST_M_HEAD;
          end
        end
        ST_M_HEAD: begin
          e_r   <= br.head;
          bh_r  <= br.head;
          bt_r  <= br.tail;
          state <= ST_M_ELEM;
        end
        ST_M_ELEM: begin
          color_r <= bpq_pkg::COLOR_BLACK;
          if ((er.col == bpq_pkg::COLOR_GRAY) && (count != '0)) begin
            count <= count - 1'b1;
          end
          if (n_ok) begin
            u_addr  <= er.nxt[bpq_pkg::ELEM_W-1:0];
            u_field <= FLD_PRV;
            u_val   <= bpq_pkg::LINK_NIL;
            u_ret   <= ST_M_COL;
            state   <= ST_U_RD;
          end else begin
            occ[sp_idx] <= 1'b0;
            state       <= ST_DONE;
          end
        end
        ST_M_COL: begin
          u_addr  <= e_r;
          u_field <= FLD_COL;
          u_val   <= bpq_pkg::LINK_W'(bpq_pkg::COLOR_BLACK);
          u_ret   <= ST_DONE;
          state   <= ST_U_RD;
        end
        ST_A_FETCH: begin
          state <= ST_A_CHECK;
        end
        ST_A_CHECK: begin
          if (!occ[tgt]) begin
            occ[tgt] <= 1'b1;
            state    <= ST_A_DONE;
          end else begin
            t_r <= br.tail;
            if (bpq_pkg::link_ok(br.tail)) begin
              u_addr  <= br.tail[bpq_pkg::ELEM_W-1:0];
              u_field <= FLD_NXT;
              u_val   <= {1'b0, e_r};
              u_ret   <= ST_A_SELF;
              state   <= ST_U_RD;
            end else begin
              state <= ST_A_SELF;
            end
          end
        end
        ST_A_SELF: begin
          state <= ST_A_DONE;
        end
        ST_A_DONE: begin
          count   <= count + 1'b1;
          color_r <= bpq_pkg::COLOR_GRAY;
          if ({1'b0, tgt} < sp) begin
            sp <= {1'b0, tgt};
          end
          state <= ST_DONE;
        end
        ST_D_NEXT: begin
          if (bpq_pkg::link_ok(n_r)) begin
            u_addr  <= n_r[bpq_pkg::ELEM_W-1:0];
            u_field <= FLD_PRV;
            u_val   <= p_r;
            u_ret   <= ST_D_COL;
            state   <= ST_U_RD;
          end else begin
            state <= ST_D_COL;
          end
        end
        ST_D_COL: begin
          u_addr  <= e_r;
          u_field <= FLD_COL;
          u_val   <= bpq_pkg::LINK_W'(bpq_pkg::COLOR_BLACK);
          u_ret   <= ST_D_DONE;
          state   <= ST_U_RD;
        end
        ST_D_DONE: begin
          if (count != '0) begin
            count <= count - 1'b1;
          end
          if (act == bpq_pkg::ACT_MOVE) begin
            tgt   <= to_r;
            state <= ST_A_FETCH;
          end else begin
            color_r <= bpq_pkg::COLOR_BLACK;
            state   <= ST_DONE;
          end
        end
        ST_U_RD: begin
          state <= ST_U_WR;
        end
        ST_U_WR: begin
          state <= u_ret;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = '{result_elem: e_r, none_found: none_r, elem_color: color_r,
                       queue_empty: (count == '0)};

endmodule

`default_nettype wire
